// ===== sv/halfsiphash_1_3_stream_defines.svh =====
// Assertion macros shared by the HalfSipHash-1-3 stream checker.
`ifndef HALFSIPHASH_1_3_STREAM_DEFINES_SVH
`define HALFSIPHASH_1_3_STREAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HSIP13_ASSERT_NOW(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HSIP13_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hsip13_pkg.sv =====
// Types, constants and round functions for the HalfSipHash-1-3 stream.
`default_nettype none

package hsip13_pkg;

  localparam logic [31:0] IV_EVEN   = 32'h6c796765;
  localparam logic [31:0] IV_ODD    = 32'h74656462;
  localparam logic [31:0] FINAL_XOR = 32'h000000ff;

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // The four hash words
  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] v3;
  } sip_state_t;

  // State plus the word still to be absorbed, handed to the finalizer
  typedef struct packed {
    sip_state_t  v;
    logic [31:0] m;
  } sip_final_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  // One SipRound of the 32-bit variant
  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1;
    t.v1 = rotl(t.v1, 5) ^ t.v0;
    t.v0 = rotl(t.v0, 16);
    t.v2 = t.v2 + t.v3;
    t.v3 = rotl(t.v3, 8) ^ t.v2;
    t.v0 = t.v0 + t.v3;
    t.v3 = rotl(t.v3, 7) ^ t.v0;
    t.v2 = t.v2 + t.v1;
    t.v1 = rotl(t.v1, 13) ^ t.v2;
    t.v2 = rotl(t.v2, 16);
    return t;
  endfunction

  // Compress one message word
  function automatic sip_state_t absorb(input sip_state_t s, input logic [31:0] m);
    sip_state_t t;
    t = s;
    t.v3 = t.v3 ^ m;
    t = sip_round(t);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

  // Initial words from the key
  function automatic sip_state_t seed(input logic [31:0] k0, input logic [31:0] k1);
    sip_state_t t;
    t.v0 = k0;
    t.v1 = k1;
    t.v2 = k0 ^ IV_EVEN;
    t.v3 = k1 ^ IV_ODD;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/halfsiphash_1_3_stream.sv =====
// Top level: keyed HalfSipHash-1-3 (32-bit result) over a byte stream.
`default_nettype none

// Takes one message byte per cycle. Bytes are packed little-endian into words
// and each full word gets one SipRound in the per-byte state update, which is
// the loop that sets the one-item-per-cycle rate. The item with tlast hands
// the state and the closing word (leftover bytes, length mod 256 on top) to a
// four-stage finalizer: absorb of the closing word with the 0xff fold, then
// three rounds, the last one computed into the output register as v1 ^ v3.
// Each message is seeded from the key registers on its first
// item, so key writes land on the next message. tuser low marks an item that
// carries no byte: with tlast it ends the message (or hashes an empty one).
// A held output result does not stop input until the finalizer fills up.
module halfsiphash_1_3_stream
  import hsip13_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] byte_valid
  input  wire logic        s_axis_tlast,
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [31:0] hash_value
);

  // key registers
  logic [31:0] key_low;
  logic [31:0] key_high;

  // running message state
  sip_state_t  v;
  logic [23:0] pending;
  logic [1:0]  byte_pos;
  logic [7:0]  len_count;
  logic        active;

  // finalizer stages
  sip_final_t  f0;
  logic        f0_valid;
  sip_state_t  sa, sb, sc;
  logic        sa_valid, sb_valid, sc_valid;
  logic        out_valid;
  logic [31:0] hash;

  logic out_ready, sc_ready, sb_ready, sa_ready, f0_ready;
  logic accept;

  sip_state_t  v_cur, v_next;
  logic [23:0] pend_cur, pend_next;
  logic [1:0]  pos_cur, pos_next;
  logic [7:0]  len_cur, len_next;
  sip_state_t  sa_next;
  sip_state_t  sc_round;

  // ready chain through the finalizer
  assign out_ready     = !out_valid || m_axis_tready;
  assign sc_ready      = !sc_valid || out_ready;
  assign sb_ready      = !sb_valid || sc_ready;
  assign sa_ready      = !sa_valid || sb_ready;
  assign f0_ready      = !f0_valid || sa_ready;
  assign s_axis_tready = f0_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // key writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_data;
        CFG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-byte update: seed on a new message, insert byte, absorb a full word
  always_comb begin
    v_cur    = active ? v : seed(key_low, key_high);
    pend_cur = active ? pending : 24'd0;
    pos_cur  = active ? byte_pos : 2'd0;
    len_cur  = active ? len_count : 8'd0;

    v_next    = v_cur;
    pend_next = pend_cur;
    pos_next  = pos_cur;
    len_next  = len_cur;
    if (s_axis_tuser) begin
      pos_next = pos_cur + 2'd1;
      len_next = len_cur + 8'd1;
      case (pos_cur)
        2'd0: pend_next[7:0]   = s_axis_tdata;
        2'd1: pend_next[15:8]  = s_axis_tdata;
        2'd2: pend_next[23:16] = s_axis_tdata;
        2'd3: begin
          v_next    = absorb(v_cur, {s_axis_tdata, pend_cur});
          pend_next = 24'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      active <= !s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v         <= v_next;
      pending   <= pend_next;
      byte_pos  <= pos_next;
      len_count <= len_next;
    end
  end

  // finalizer valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid  <= 1'b0;
      sa_valid  <= 1'b0;
      sb_valid  <= 1'b0;
      sc_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (f0_ready)  f0_valid  <= accept && s_axis_tlast;
      if (sa_ready)  sa_valid  <= f0_valid;
      if (sb_ready)  sb_valid  <= sa_valid;
      if (sc_ready)  sc_valid  <= sb_valid;
      if (out_ready) out_valid <= sc_valid;
    end
  end

  // closing word absorb with the 0xff fold on v2
  always_comb begin
    sa_next    = absorb(f0.v, f0.m);
    sa_next.v2 = sa_next.v2 ^ FINAL_XOR;
  end

  assign sc_round = sip_round(sc);

  // finalizer payload: closing word, 0xff fold, three rounds
  always_ff @(posedge clk) begin
    if (f0_ready) begin
      f0.v <= v_next;
      f0.m <= {len_next, pend_next};
    end
    if (sa_ready)  sa   <= sa_next;
    if (sb_ready)  sb   <= sip_round(sa);
    if (sc_ready)  sc   <= sip_round(sb);
    if (out_ready) hash <= sc_round.v1 ^ sc_round.v3;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = hash;

endmodule

`default_nettype wire

// ===== sv/hsip13_checker.sv =====
// Port-level checker for the HalfSipHash-1-3 stream, bound to the top level.
`default_nettype none

`include "halfsiphash_1_3_stream_defines.svh"

module hsip13_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // finalizer stages plus the output register
  localparam logic [2:0] PipeDepth = 3'd5;

  logic [2:0] open_items;
  logic       in_end;
  logic       out_take;

  assign in_end   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // messages ended but hash not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
    end else begin
      case ({in_end, out_take})
        2'b10:   open_items <= open_items + 3'd1;
        2'b01:   open_items <= open_items - 3'd1;
        default: open_items <= open_items;
      endcase
    end
  end

  `HSIP13_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled hash item changed or dropped")
  `HSIP13_ASSERT_NOW(a_no_spurious, m_axis_tvalid, open_items != 3'd0,
    "hash item without an ended message")
  `HSIP13_ASSERT_NOW(a_depth, 1'b1, open_items <= PipeDepth,
    "more messages in flight than finalizer stages")
  `HSIP13_ASSERT_NOW(a_stall_cause, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready, "input stalled while output is free")

endmodule

bind halfsiphash_1_3_stream hsip13_checker u_hsip13_checker (.*);

`default_nettype wire
